/* sv/mep_pkg.sv */
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types, constants and saturation helpers for the escape-time block.
// ----------------------------------------------------------------------------
package mep_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 13;
    localparam int ITER_BITS  = 16;
    localparam int Z_BITS     = FRAC_BITS + 8;
    localparam int MAG_BITS   = Z_BITS - 1;
    localparam int HALF_BITS  = (MAG_BITS + 1) / 2;
    localparam int HI_BITS    = MAG_BITS - HALF_BITS;
    localparam int PROD_BITS  = 2 * MAG_BITS;
    localparam int SUM_BITS   = Z_BITS + 2;
    localparam int TQ         = 24;
    localparam int QW         = TQ + 1;
    localparam int CNT_BITS   = $clog2(TQ);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [Z_BITS-1:0]   t_z;
    typedef logic [MAG_BITS-1:0]        t_mag;
    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic [ITER_BITS-1:0]       t_iter;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    localparam t_z ZMAX = {1'b0, {(Z_BITS-1){1'b1}}};
    localparam logic [Z_BITS:0] FOUR = (Z_BITS+1)'(4) << FRAC_BITS;

    localparam t_cfg_idx CFG_X_MIN  = 3'd0;
    localparam t_cfg_idx CFG_X_STEP = 3'd1;
    localparam t_cfg_idx CFG_Y_MAX  = 3'd2;
    localparam t_cfg_idx CFG_Y_STEP = 3'd3;
    localparam t_cfg_idx CFG_LIMIT  = 3'd4;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_z     cr;
        t_z     ci;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MUL_LO, S_MUL_HI, S_SCALE, S_ADD1, S_ADD2,
        S_DIV, S_COL1, S_COL2, S_COL3, S_COL4, S_OUT
    } t_core_state;

    function automatic t_z sat_z(input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'(ZMAX);
        lo = -hi;
        if (v > hi) begin
            return ZMAX;
        end else if (v < lo) begin
            return -ZMAX;
        end
        return v[Z_BITS-1:0];
    endfunction

    function automatic t_mag abs_z(input t_z v);
        t_z a;
        a = v[Z_BITS-1] ? -v : v;
        return a[MAG_BITS-1:0];
    endfunction

endpackage

/* sv/mep_front.sv */
// ----------------------------------------------------------------------------
// mep_front
// Maps a pixel position to the point c: two step products, then add and clamp.
// ----------------------------------------------------------------------------
module mep_front
    import mep_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  t_coord                 i_pixel_x,
    input  t_coord                 i_pixel_y,
    input  logic signed [31:0]     i_x_min,
    input  logic [30:0]            i_x_step,
    input  logic signed [31:0]     i_y_max,
    input  logic [30:0]            i_y_step,
    input  logic                   i_full,
    output logic                   o_busy,
    output logic                   o_push,
    output t_job                   o_job
);

    localparam int PW = COORD_BITS + 31;
    localparam int SW = PW + 2;

    logic          r_v1, r_v2;
    t_coord        r_x1, r_y1;
    logic [PW-1:0] r_px, r_py;
    t_job          r_job;

    logic signed [SW-1:0] n_cr_full, n_ci_full;
    logic signed [SW-1:0] zhi, zlo;
    t_z                   n_cr, n_ci;

    assign zhi = SW'(ZMAX);
    assign zlo = -zhi;

    always_comb begin
        n_cr_full = SW'(i_x_min) + $signed({2'b00, r_px});
        n_ci_full = SW'(i_y_max) - $signed({2'b00, r_py});
        n_cr = (n_cr_full > zhi) ? ZMAX : (n_cr_full < zlo) ? -ZMAX : n_cr_full[Z_BITS-1:0];
        n_ci = (n_ci_full > zhi) ? ZMAX : (n_ci_full < zlo) ? -ZMAX : n_ci_full[Z_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                r_v1 <= 1'b1;
            end else if (r_v1 && !r_v2) begin
                r_v1 <= 1'b0;
            end
            if (r_v1 && !r_v2) begin
                r_v2 <= 1'b1;
            end else if (r_v2 && !i_full) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_x1 <= i_pixel_x;
            r_y1 <= i_pixel_y;
            r_px <= PW'(i_pixel_x) * PW'(i_x_step);
            r_py <= PW'(i_pixel_y) * PW'(i_y_step);
        end
        if (r_v1 && !r_v2) begin
            r_job.x  <= r_x1;
            r_job.y  <= r_y1;
            r_job.cr <= n_cr;
            r_job.ci <= n_ci;
        end
    end

    assign o_busy = r_v1 || r_v2;
    assign o_push = r_v2 && !i_full;
    assign o_job  = r_job;

endmodule

/* sv/mep_queue.sv */
// ----------------------------------------------------------------------------
// mep_queue
// Two-entry job queue between the coordinate front end and the iteration core.
// ----------------------------------------------------------------------------
module mep_queue
    import mep_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

endmodule

/* sv/mep_core.sv */
// ----------------------------------------------------------------------------
// mep_core
// Escape-time iteration sequencer with split multiplies, divider and colour map.
// ----------------------------------------------------------------------------
module mep_core
    import mep_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_job   i_job,
    input  t_iter  i_limit,
    output logic   o_pop,
    output logic   o_valid,
    output t_coord o_x,
    output t_coord o_y,
    output t_iter  o_iterations,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    localparam int P1_BITS = MAG_BITS + HALF_BITS;
    localparam int CP_BITS = 2 * QW;
    localparam int CC_BITS = QW + 12;

    t_core_state r_state, n_state;

    t_job  r_job;
    t_z    r_re, r_im, r_re2, r_im2, r_rim, r_t, r_nim;
    t_mag  r_mre, r_mim;
    logic  r_neg;
    t_iter r_n;
    logic [P1_BITS-1:0]   r_prr, r_pii, r_pri;
    logic [PROD_BITS-1:0] r_arr, r_aii, r_ari;
    logic [ITER_BITS:0]   r_rem;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [QW-1:0] r_tq, r_uq, r_t2, r_u2, r_t3, r_u3, r_tu, r_a, r_b;
    logic [7:0]    r_red, r_green, r_blue;

    logic [SUM_BITS-1:0]  n_mag2;
    logic                 n_escape;
    logic [ITER_BITS:0]   n_rem2;
    logic [PROD_BITS-FRAC_BITS-1:0] n_qrr, n_qii;
    logic [PROD_BITS-FRAC_BITS:0]   n_qri;
    t_z                   n_rre, n_rii, n_rri;
    logic [CC_BITS-1:0]   n_cr, n_cg, n_cb;
    logic [CP_BITS-1:0]   m_t2, m_u2, m_t3, m_u3, m_tu, m_a, m_b;

    always_comb begin
        n_mag2   = SUM_BITS'(r_re2) + SUM_BITS'(r_im2);
        n_escape = n_mag2 > SUM_BITS'(FOUR);
        n_rem2   = {r_rem[ITER_BITS-1:0], 1'b0};
        n_qrr    = r_arr[PROD_BITS-1:FRAC_BITS];
        n_qii    = r_aii[PROD_BITS-1:FRAC_BITS];
        n_qri    = r_ari[PROD_BITS-1:FRAC_BITS-1];
        n_rre    = (n_qrr > ($bits(n_qrr))'(ZMAX)) ? ZMAX : n_qrr[Z_BITS-1:0];
        n_rii    = (n_qii > ($bits(n_qii))'(ZMAX)) ? ZMAX : n_qii[Z_BITS-1:0];
        n_rri    = (n_qri > ($bits(n_qri))'(ZMAX)) ? ZMAX : n_qri[Z_BITS-1:0];
        m_t2 = CP_BITS'(r_tq) * CP_BITS'(r_tq);
        m_u2 = CP_BITS'(r_uq) * CP_BITS'(r_uq);
        m_t3 = CP_BITS'(r_t2) * CP_BITS'(r_tq);
        m_u3 = CP_BITS'(r_u2) * CP_BITS'(r_uq);
        m_tu = CP_BITS'(r_t2) * CP_BITS'(r_u2);
        m_a  = CP_BITS'(r_t3) * CP_BITS'(r_uq);
        m_b  = CP_BITS'(r_tq) * CP_BITS'(r_u3);
        n_cr = (CC_BITS'(2295) * CC_BITS'(r_a)) >> TQ;
        n_cg = (CC_BITS'(3825) * CC_BITS'(r_tu)) >> TQ;
        n_cb = (CC_BITS'(4335) * CC_BITS'(r_b)) >> (TQ + 1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_CHECK;
            S_CHECK:  n_state = (r_n < i_limit) ? S_MUL_LO : S_OUT;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_SCALE;
            S_SCALE:  n_state = S_ADD1;
            S_ADD1:   n_state = n_escape ? S_DIV : S_ADD2;
            S_ADD2:   n_state = S_CHECK;
            S_DIV:    if (r_cnt == CNT_BITS'(TQ - 1)) n_state = S_COL1;
            S_COL1:   n_state = S_COL2;
            S_COL2:   n_state = S_COL3;
            S_COL3:   n_state = S_COL4;
            S_COL4:   n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = (r_state == S_IDLE) && i_valid;
        o_valid = (r_state == S_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job   <= i_job;
                r_re    <= '0;
                r_im    <= '0;
                r_n     <= '0;
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
            end
            S_CHECK: begin
                r_mre <= abs_z(r_re);
                r_mim <= abs_z(r_im);
                r_neg <= r_re[Z_BITS-1] ^ r_im[Z_BITS-1];
            end
            S_MUL_LO: begin
                r_prr <= P1_BITS'(r_mre) * P1_BITS'(r_mre[HALF_BITS-1:0]);
                r_pii <= P1_BITS'(r_mim) * P1_BITS'(r_mim[HALF_BITS-1:0]);
                r_pri <= P1_BITS'(r_mre) * P1_BITS'(r_mim[HALF_BITS-1:0]);
            end
            S_MUL_HI: begin
                r_arr <= PROD_BITS'(r_prr)
                       + ((PROD_BITS'(r_mre) * PROD_BITS'(r_mre[MAG_BITS-1:HALF_BITS]))
                          << HALF_BITS);
                r_aii <= PROD_BITS'(r_pii)
                       + ((PROD_BITS'(r_mim) * PROD_BITS'(r_mim[MAG_BITS-1:HALF_BITS]))
                          << HALF_BITS);
                r_ari <= PROD_BITS'(r_pri)
                       + ((PROD_BITS'(r_mre) * PROD_BITS'(r_mim[MAG_BITS-1:HALF_BITS]))
                          << HALF_BITS);
            end
            S_SCALE: begin
                r_re2 <= n_rre;
                r_im2 <= n_rii;
                r_rim <= r_neg ? -n_rri : n_rri;
            end
            S_ADD1: begin
                r_t   <= sat_z(SUM_BITS'(r_re2) - SUM_BITS'(r_im2));
                r_nim <= sat_z(SUM_BITS'(r_rim) + SUM_BITS'(r_job.ci));
                r_rem <= {1'b0, r_n};
                r_cnt <= '0;
            end
            S_ADD2: begin
                r_re <= sat_z(SUM_BITS'(r_t) + SUM_BITS'(r_job.cr));
                r_im <= r_nim;
                r_n  <= r_n + 1'b1;
            end
            S_DIV: begin
                // restoring division, one quotient bit a beat
                if (n_rem2 >= (ITER_BITS+1)'(i_limit)) begin
                    r_rem <= n_rem2 - (ITER_BITS+1)'(i_limit);
                    r_tq  <= {r_tq[QW-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem2;
                    r_tq  <= {r_tq[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_COL1: begin
                r_tq <= {1'b0, r_tq[TQ-1:0]};
                r_uq <= (QW'(1) << TQ) - {1'b0, r_tq[TQ-1:0]};
            end
            S_COL2: begin
                r_t2 <= QW'(m_t2 >> TQ);
                r_u2 <= QW'(m_u2 >> TQ);
            end
            S_COL3: begin
                r_t3 <= QW'(m_t3 >> TQ);
                r_u3 <= QW'(m_u3 >> TQ);
                r_tu <= QW'(m_tu >> TQ);
            end
            S_COL4: begin
                r_a <= QW'(m_a >> TQ);
                r_b <= QW'(m_b >> TQ);
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
        if (r_state == S_OUT && r_n < i_limit) begin
            r_red   <= (n_cr > CC_BITS'(255)) ? 8'hFF : n_cr[7:0];
            r_green <= (n_cg > CC_BITS'(255)) ? 8'hFF : n_cg[7:0];
            r_blue  <= (n_cb > CC_BITS'(255)) ? 8'hFF : n_cb[7:0];
        end
    end

    // colour is finalised on the way into the output beat
    logic [7:0] n_red, n_green, n_blue;
    always_comb begin
        n_red   = (n_cr > CC_BITS'(255)) ? 8'hFF : n_cr[7:0];
        n_green = (n_cg > CC_BITS'(255)) ? 8'hFF : n_cg[7:0];
        n_blue  = (n_cb > CC_BITS'(255)) ? 8'hFF : n_cb[7:0];
    end

    logic n_black;
    assign n_black = (r_n >= i_limit);

    assign o_x          = r_job.x;
    assign o_y          = r_job.y;
    assign o_iterations = r_n;
    assign o_red        = n_black ? 8'h00 : (o_valid ? n_red   : r_red);
    assign o_green      = n_black ? 8'h00 : (o_valid ? n_green : r_green);
    assign o_blue       = n_black ? 8'h00 : (o_valid ? n_blue  : r_blue);

endmodule

/* sv/mandelbrot_escape_pixel_top.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top
// Front end: step products, then the clamped point c, pushed into the queue.
// Each iteration steps CHECK, MUL_LO, MUL_HI, SCALE, ADD1, ADD2. At the limit
// CHECK leads to the result beat; on escape, 24-step division and 4 colour
// stages come first. The core pops the next job only after the result beat.
// Synchronous active-low reset clears control state and loads register defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top
    import mep_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  t_coord          i_pixel_x,
    input  t_coord          i_pixel_y,
    input  logic            i_cfg_we,
    input  t_cfg_idx        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic            o_valid,
    output t_coord          o_out_x,
    output t_coord          o_out_y,
    output t_iter           o_iterations,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue
);

    logic signed [31:0] r_x_min, r_y_max;
    logic [30:0]        r_x_step, r_y_step;
    t_iter              r_limit;

    logic push, full, qvalid, pop;
    t_job fjob, qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min  <= -32'sd536870912;
            r_x_step <= 31'd115341;
            r_y_max  <= 32'sd322122547;
            r_y_step <= 31'd149165;
            r_limit  <= ITER_BITS'(10000);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_MIN:  r_x_min  <= i_cfg_data;
                CFG_X_STEP: r_x_step <= i_cfg_data[30:0];
                CFG_Y_MAX:  r_y_max  <= i_cfg_data;
                CFG_Y_STEP: r_y_step <= i_cfg_data[30:0];
                CFG_LIMIT:  r_limit  <= i_cfg_data[ITER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    mep_front u_front (
        .i_clk, .i_rst_n,
        .i_start   (start),
        .i_pixel_x,
        .i_pixel_y,
        .i_x_min   (r_x_min),
        .i_x_step  (r_x_step),
        .i_y_max   (r_y_max),
        .i_y_step  (r_y_step),
        .i_full    (full),
        .o_busy    (busy),
        .o_push    (push),
        .o_job     (fjob)
    );

    mep_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push  (push),
        .i_job   (fjob),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (qvalid),
        .o_job   (qjob)
    );

    mep_core u_core (
        .i_clk, .i_rst_n,
        .i_valid      (qvalid),
        .i_job        (qjob),
        .i_limit      (r_limit),
        .o_pop        (pop),
        .o_valid,
        .o_x          (o_out_x),
        .o_y          (o_out_y),
        .o_iterations,
        .o_red,
        .o_green,
        .o_blue
    );

endmodule

/* sv/mep_checker.sv */
// ----------------------------------------------------------------------------
// mep_checker
// Port-level checks on the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module mep_checker
    import mep_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input t_iter      o_iterations,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    // a result beat is always followed by a gap
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("back-to-back result beats");

    // an immediate escape has t = 0, so every channel is dark
    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_iterations == '0) |-> (o_red == 8'h00 && o_green == 8'h00
        && o_blue == 8'h00)) else $error("colour on zero-iteration result");

    // an accepted pixel occupies the front end on the next beat
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted pixel not held");

    // no result beat appears during reset or at its release
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result straight after reset");

endmodule

bind mandelbrot_escape_pixel_top mep_checker u_mep_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_iterations (o_iterations),
    .o_red        (o_red),
    .o_green      (o_green),
    .o_blue       (o_blue)
);
